/* rtl/rtu_pkg.sv */
`timescale 1ns / 1ps
// Types and constants shared by the RTU frame receiver modules.
package rtu_pkg;

   // Input word operation codes.
   localparam logic [1:0] OP_BYTE     = 2'd0;
   localparam logic [1:0] OP_TIMEOUT  = 2'd1;
   localparam logic [1:0] OP_RX_ERROR = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_GOOD   = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   // Control register indexes.
   localparam logic [1:0] REG_OWN_ADDRESS     = 2'd0;
   localparam logic [1:0] REG_CHECK_MODE      = 2'd1;
   localparam logic [1:0] REG_FUNCTION_FILTER = 2'd2;
   localparam logic [1:0] REG_MAX_DATA_LENGTH = 2'd3;

   // Control register reset values.
   localparam logic [7:0] RST_OWN_ADDRESS     = 8'd1;
   localparam logic       RST_CHECK_MODE      = 1'b0;
   localparam logic [7:0] RST_FUNCTION_FILTER = 8'd0;
   localparam logic [5:0] RST_MAX_DATA_LENGTH = 6'd10;

   // Check mode encoding.
   localparam logic CHECK_CRC = 1'b0;
   localparam logic CHECK_SUM = 1'b1;

   // Frame layout: address, function and length in front, two check bytes behind.
   localparam int HEADER_LEN  = 3;
   localparam int TRAILER_LEN = 2;

   // Check arithmetic.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] SUM_INIT = 16'h0000;
   localparam int CRC_ITERS         = 4;
   localparam int CRC_BITS_PER_ITER = 2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] frame_byte;
      logic       last;
   } rsp_type;

   // Request from the sequencer to the check unit.
   typedef struct packed {
      logic       start;
      logic       init;
      logic       sum_mode;
      logic [7:0] data;
   } chk_cmd_type;

   // Status from the check unit back to the sequencer.
   typedef struct packed {
      logic        busy;
      logic [15:0] value;
   } chk_sts_type;

endpackage

/* rtl/rtu_frame_receiver.sv */
`timescale 1ns / 1ps
// Top level of the RTU frame receiver: byte sequencer, frame store and readout.
//
// Usage: each input word on req_* is a received byte, a timeout or a receive error.
// Bytes are dropped until one equals the own address; then function, length, data
// and a two-byte check (low byte first) are collected in the frame store. In CRC
// mode the check is the Modbus CRC-16; in sum mode it is a 16-bit byte sum and the
// function code and length are filtered. A good frame comes out on rsp_* as one
// word per header and data byte, last set on the final one; a wrong check gives a
// single reject word. The user must write registers on csr_* only while the block
// is idle; the block itself does not enforce it. Input: in CRC mode a byte that
// enters the check stalls further input while the shared CRC unit shifts it, two
// bits per cycle; in sum mode no such stall arises. A good frame is read from the
// store one result word at a time through S_RD_ADDR, the registered read port and
// S_RD_DATA into the output register; the block takes no input during readout or
// while a reject word waits in S_REJECT, which then feeds the output register.
// When rsp_stall is high the output register holds its word and the sequencer
// waits; the next input word can still be taken while the last result waits.
// Reset clears the parser to wait for an address and loads register defaults;
// the frame store needs no clearing.
module rtu_frame_receiver import rtu_pkg::*; #(
   parameter int MAX_FRAME = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int IDX_W      = $clog2(MAX_FRAME + 1);
   localparam int ADDR_W     = $clog2(MAX_FRAME);
   localparam int DATA_LIMIT = MAX_FRAME - HEADER_LEN - TRAILER_LEN;
   localparam logic [7:0]       DATA_LIMIT_B = 8'(DATA_LIMIT);
   localparam logic [IDX_W-1:0] IDX_FULL     = IDX_W'(MAX_FRAME);
   localparam logic [IDX_W-1:0] IDX_DATA     = IDX_W'(HEADER_LEN);

   // Sequencer states.
   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_RD_ADDR = 2'd1;
   localparam logic [1:0] S_RD_DATA = 2'd2;
   localparam logic [1:0] S_REJECT  = 2'd3;

   // Parser phases.
   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_FUNC = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   logic [7:0]       own_address_ff, own_address_in;
   logic             check_mode_ff, check_mode_in;
   logic [7:0]       function_filter_ff, function_filter_in;
   logic [5:0]       max_data_length_ff, max_data_length_in;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [7:0]       data_length_ff, data_length_in;
   logic [7:0]       prev_byte_ff, prev_byte_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [7:0]        ram_rd_data;

   chk_cmd_type chk_cmd;
   chk_sts_type chk_sts;

   logic             req_accept;
   logic             rsp_free;
   logic             sum_mode;
   logic [7:0]       data_limit;
   logic [8:0]       hdr_count;
   logic [8:0]       frame_total;
   logic [IDX_W-1:0] widx_next;
   logic [15:0]      rx_check;
   logic             rd_last;

   rtu_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   rtu_check_unit u_check (
      .clock (clock),
      .reset (reset),
      .cmd   (chk_cmd),
      .sts   (chk_sts)
   );

   // Handshake and frame arithmetic.
   assign req_stall   = (state_ff != S_IDLE) || chk_sts.busy;
   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign sum_mode    = (check_mode_ff == CHECK_SUM);
   assign data_limit  = ({2'b00, max_data_length_ff} > DATA_LIMIT_B) ?
                        DATA_LIMIT_B : {2'b00, max_data_length_ff};
   assign hdr_count   = {1'b0, data_length_ff} + 9'(HEADER_LEN);
   assign frame_total = hdr_count + 9'(TRAILER_LEN);
   assign widx_next   = IDX_W'(widx_ff + 1'b1);
   assign rx_check    = {req_data.rx_byte, prev_byte_ff};
   assign rd_last     = (9'(rd_idx_ff) + 9'd1) == hdr_count;

   // Control register writes.
   always_comb begin
      own_address_in     = own_address_ff;
      check_mode_in      = check_mode_ff;
      function_filter_in = function_filter_ff;
      max_data_length_in = max_data_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_OWN_ADDRESS:     own_address_in     = csr_wdata;
            REG_CHECK_MODE:      check_mode_in      = csr_wdata[0];
            REG_FUNCTION_FILTER: function_filter_in = csr_wdata;
            REG_MAX_DATA_LENGTH: max_data_length_in = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Parser and readout sequencer.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      widx_in        = widx_ff;
      data_length_in = data_length_ff;
      prev_byte_in   = prev_byte_ff;
      rd_idx_in      = rd_idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_rd_en      = 1'b0;
      chk_cmd.start    = 1'b0;
      chk_cmd.init     = 1'b0;
      chk_cmd.sum_mode = sum_mode;
      chk_cmd.data     = req_data.rx_byte;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_data.op)
                  OP_TIMEOUT: begin
                     phase_in = PH_ADDR;
                  end
                  OP_RX_ERROR: begin
                     phase_in = PH_ADDR;
                     widx_in  = '0;
                  end
                  OP_BYTE: begin
                     unique case (phase_ff)
                        PH_ADDR: begin
                           if (req_data.rx_byte == own_address_ff) begin
                              ram_wr_en     = 1'b1;
                              ram_wr_addr   = ADDR_W'(0);
                              chk_cmd.start = 1'b1;
                              chk_cmd.init  = 1'b1;
                              phase_in      = PH_FUNC;
                           end
                        end
                        PH_FUNC: begin
                           if (sum_mode && req_data.rx_byte != function_filter_ff) begin
                              phase_in = PH_ADDR;
                           end else begin
                              ram_wr_en     = 1'b1;
                              ram_wr_addr   = ADDR_W'(1);
                              chk_cmd.start = 1'b1;
                              phase_in      = PH_LEN;
                           end
                        end
                        PH_LEN: begin
                           data_length_in = req_data.rx_byte;
                           if (sum_mode && (req_data.rx_byte == 8'd0 ||
                                            req_data.rx_byte > data_limit)) begin
                              phase_in = PH_ADDR;
                              widx_in  = '0;
                           end else begin
                              ram_wr_en     = 1'b1;
                              ram_wr_addr   = ADDR_W'(2);
                              chk_cmd.start = 1'b1;
                              widx_in       = IDX_DATA;
                              phase_in      = PH_DATA;
                           end
                        end
                        PH_DATA: begin
                           if (widx_ff >= IDX_FULL) begin
                              // Frame too long for the store: drop it.
                              widx_in  = IDX_DATA;
                              phase_in = PH_ADDR;
                           end else begin
                              ram_wr_en    = 1'b1;
                              ram_wr_addr  = widx_ff[ADDR_W-1:0];
                              widx_in      = widx_next;
                              prev_byte_in = req_data.rx_byte;
                              if (9'(widx_ff) < hdr_count) begin
                                 chk_cmd.start = 1'b1;
                              end
                              // The final check byte closes the frame.
                              if (9'(widx_next) >= frame_total) begin
                                 phase_in = PH_ADDR;
                                 if (rx_check != chk_sts.value) begin
                                    state_in = S_REJECT;
                                 end else begin
                                    rd_idx_in = '0;
                                    state_in  = S_RD_ADDR;
                                 end
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         S_RD_ADDR: begin
            ram_rd_en = 1'b1;
            state_in  = S_RD_DATA;
         end
         S_RD_DATA: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = STATUS_GOOD;
               rsp_in.frame_byte = ram_rd_data;
               rsp_in.last       = rd_last;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = ADDR_W'(rd_idx_ff + 1'b1);
                  state_in  = S_RD_ADDR;
               end
            end
         end
         S_REJECT: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = STATUS_REJECT;
               rsp_in.frame_byte = 8'd0;
               rsp_in.last       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff     <= RST_OWN_ADDRESS;
         check_mode_ff      <= RST_CHECK_MODE;
         function_filter_ff <= RST_FUNCTION_FILTER;
         max_data_length_ff <= RST_MAX_DATA_LENGTH;
         state_ff           <= S_IDLE;
         phase_ff           <= PH_ADDR;
         widx_ff            <= '0;
         rd_idx_ff          <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         own_address_ff     <= own_address_in;
         check_mode_ff      <= check_mode_in;
         function_filter_ff <= function_filter_in;
         max_data_length_ff <= max_data_length_in;
         state_ff           <= state_in;
         phase_ff           <= phase_in;
         widx_ff            <= widx_in;
         rd_idx_ff          <= rd_idx_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      data_length_ff <= data_length_in;
      prev_byte_ff   <= prev_byte_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // While collecting data the write index stays between the first data slot and one past the end of the store.
   a_widx_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (widx_ff >= IDX_DATA) && (widx_ff <= IDX_FULL))
      else $error("write index out of range in data phase");

   // Readout never runs past the header and data bytes of the frame.
   a_readout_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD_DATA |-> 9'(rd_idx_ff) < hdr_count)
      else $error("readout index past end of frame");

   // A reject word is always the only, and so the last, word of its input.
   a_reject_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_REJECT |->
         rsp_data.last && rsp_data.frame_byte == 8'd0)
      else $error("malformed reject word");

endmodule

/* rtl/rtu_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rtu_check_unit.sv */
`timescale 1ns / 1ps
// Shared frame check unit: CRC-16 two bits per cycle, or a byte sum that needs no shift iterations.
module rtu_check_unit import rtu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  chk_cmd_type cmd,
   output chk_sts_type sts
);

   localparam int CNT_W = $clog2(CRC_ITERS);

   logic [15:0]      value_ff, value_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      seed;

   // Two bit steps of the reflected CRC shift register.
   function automatic logic [15:0] crc_shift(input logic [15:0] c);
      logic [15:0] r;
      r = c;
      for (int i = 0; i < CRC_BITS_PER_ITER; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // A start folds the byte in; CRC mode then runs the shift iterations.
   always_comb begin
      value_in = value_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      seed     = cmd.init ? (cmd.sum_mode ? SUM_INIT : CRC_INIT) : value_ff;
      if (cmd.start) begin
         if (cmd.sum_mode) begin
            value_in = seed + {8'd0, cmd.data};
         end else begin
            value_in = seed ^ {8'd0, cmd.data};
            busy_in  = 1'b1;
            count_in = '0;
         end
      end else if (busy_ff) begin
         value_in = crc_shift(value_ff);
         count_in = CNT_W'(count_ff + 1'b1);
         if (count_ff == CNT_W'(CRC_ITERS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      value_ff <= value_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.value = value_ff;

   // The sequencer never starts a byte while the shift iterations still run.
   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("check unit started while busy");

   // Busy clears after the last CRC iteration when no start comes with it.
   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && count_ff == CNT_W'(CRC_ITERS - 1) && !cmd.start |=> !busy_ff)
      else $error("check unit stayed busy past its last iteration");

endmodule

/* tb/sv/rtu_frame_checker.sv */
`timescale 1ns / 1ps
// Frame check arithmetic and the checker that predicts and compares the receiver's output words.
package rtu_check_pkg;
   import rtu_pkg::*;

   // Fold one byte into a running frame check: 16-bit byte sum or Modbus CRC-16.
   function automatic logic [15:0] check_next(input logic mode, input logic [15:0] acc,
                                              input logic [7:0] value);
      logic [15:0] crc;
      if (mode == CHECK_SUM) begin
         return acc + 16'(value);
      end
      crc = acc ^ {8'h00, value};
      for (int i = 0; i < 8; i++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction
endpackage

module rtu_frame_checker import rtu_pkg::*; import rtu_check_pkg::*; #(
   parameter int MAX_FRAME = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         failures,
   output int         outstanding
);

   localparam int PRINT_CAP = 100;

   typedef enum logic [1:0] {
      PH_ADDRESS,
      PH_FUNCTION,
      PH_LENGTH,
      PH_BODY
   } parse_state_type;

   // Shadow copy of the control registers.
   logic [7:0] own_address_q;
   logic       check_mode_q;
   logic [7:0] filter_q;
   logic [5:0] max_len_q;

   // Shadow copy of the parser.
   parse_state_type parse_state;
   logic [7:0]   frame_bytes [MAX_FRAME];
   int           wr_index;
   logic [7:0]   len_q;
   logic [15:0]  running_check;

   rsp_type expected_words [$];

   task automatic report_mismatch(input string what, input int want, input int got);
      if (failures < PRINT_CAP) begin
         $display("%0t frame check: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
      end
      failures++;
   endtask

   // Compare one output word with the oldest expected word.
   task automatic compare_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("unexpected word", 0, int'(got));
         return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status) begin
         report_mismatch("status", int'(want.status), int'(got.status));
      end
      if (got.frame_byte !== want.frame_byte) begin
         report_mismatch("frame_byte", int'(want.frame_byte), int'(got.frame_byte));
      end
      if (got.last !== want.last) report_mismatch("last", int'(want.last), int'(got.last));
   endtask

   // Advance the parser by one input word and queue the words it releases.
   task automatic parse_word(input req_type w);
      int         limit;
      int         total;
      int         n;
      logic [15:0] rx_check;
      case (w.op)
         OP_TIMEOUT: parse_state = PH_ADDRESS;
         OP_RX_ERROR: begin
            parse_state = PH_ADDRESS;
            wr_index = 0;
         end
         OP_BYTE: begin
            case (parse_state)
               PH_ADDRESS: begin
                  if (w.rx_byte == own_address_q) begin
                     running_check = check_next(check_mode_q,
                        (check_mode_q == CHECK_SUM) ? SUM_INIT : CRC_INIT, w.rx_byte);
                     frame_bytes[0] = w.rx_byte;
                     parse_state = PH_FUNCTION;
                  end
               end
               PH_FUNCTION: begin
                  if (check_mode_q == CHECK_SUM && w.rx_byte != filter_q) begin
                     parse_state = PH_ADDRESS;
                  end else begin
                     running_check = check_next(check_mode_q, running_check, w.rx_byte);
                     frame_bytes[1] = w.rx_byte;
                     parse_state = PH_LENGTH;
                  end
               end
               PH_LENGTH: begin
                  len_q = w.rx_byte;
                  limit = int'(max_len_q);
                  if (limit > MAX_FRAME - HEADER_LEN - TRAILER_LEN) begin
                     limit = MAX_FRAME - HEADER_LEN - TRAILER_LEN;
                  end
                  if (check_mode_q == CHECK_SUM && (w.rx_byte == 0 || int'(w.rx_byte) > limit))
                  begin
                     parse_state = PH_ADDRESS;
                     wr_index = 0;
                  end else begin
                     running_check = check_next(check_mode_q, running_check, w.rx_byte);
                     frame_bytes[2] = w.rx_byte;
                     wr_index = HEADER_LEN;
                     parse_state = PH_BODY;
                  end
               end
               default: begin
                  // A byte past the end of the store drops the whole frame.
                  if (wr_index >= MAX_FRAME) begin
                     wr_index = HEADER_LEN;
                     parse_state = PH_ADDRESS;
                  end else begin
                     frame_bytes[wr_index] = w.rx_byte;
                     if (wr_index < int'(len_q) + HEADER_LEN) begin
                        running_check = check_next(check_mode_q, running_check, w.rx_byte);
                     end
                     wr_index++;
                     total = int'(len_q) + HEADER_LEN + TRAILER_LEN;
                     if (wr_index >= total) begin
                        parse_state = PH_ADDRESS;
                        n = int'(len_q) + HEADER_LEN;
                        rx_check = {frame_bytes[n + 1], frame_bytes[n]};
                        if (rx_check != running_check) begin
                           expected_words.push_back('{status: STATUS_REJECT, frame_byte: 8'h00,
                                                      last: 1'b1});
                        end else begin
                           for (int i = 0; i < n; i++) begin
                              expected_words.push_back('{status: STATUS_GOOD,
                                 frame_byte: frame_bytes[i], last: (i + 1 == n)});
                           end
                        end
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
   endtask

   // Watch the three ports on every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         own_address_q = RST_OWN_ADDRESS;
         check_mode_q = RST_CHECK_MODE;
         filter_q = RST_FUNCTION_FILTER;
         max_len_q = RST_MAX_DATA_LENGTH;
         parse_state = PH_ADDRESS;
         wr_index = 0;
         len_q = 8'h00;
         running_check = 16'h0000;
         expected_words.delete();
         failures = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) compare_word(rsp_data);
         if (csr_write) begin
            case (csr_index)
               REG_OWN_ADDRESS:     own_address_q = csr_wdata;
               REG_CHECK_MODE:      check_mode_q = csr_wdata[0];
               REG_FUNCTION_FILTER: filter_q = csr_wdata;
               REG_MAX_DATA_LENGTH: max_len_q = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) parse_word(req_data);
         outstanding <= expected_words.size();
      end
   end

endmodule

/* tb/sv/rtu_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the RTU frame receiver: clock, reset, stimulus phases and the verdict.
module rtu_frame_receiver_tb;
   import rtu_pkg::*;
   import rtu_check_pkg::*;

   localparam int MAX_FRAME       = 16;
   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 20;
   localparam int LIMIT_CYCLES    = 200000;
   localparam int WORDS_PER_PHASE = 24;
   localparam int PHASE_COUNT     = 6;
   localparam int DATA_CAP        = MAX_FRAME - TRAILER_LEN;
   localparam int SUM_LEN_CAP     = MAX_FRAME - HEADER_LEN - TRAILER_LEN;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   int failures;
   int outstanding;
   int words_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // Register values as last written, used to build frames that pass.
   logic [7:0] cur_own = RST_OWN_ADDRESS;
   logic       cur_mode = RST_CHECK_MODE;
   logic [7:0] cur_filter = RST_FUNCTION_FILTER;
   logic [5:0] cur_max = RST_MAX_DATA_LENGTH;

   rtu_frame_receiver #(.MAX_FRAME(MAX_FRAME)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rtu_frame_checker #(.MAX_FRAME(MAX_FRAME)) frame_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .outstanding(outstanding)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // The output side stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Cycle counter that ends a run that hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Offer one word, with random idle cycles in front, and wait until it is taken.
   task automatic send_word(input req_type w);
      logic stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      if (w.op != OP_UNUSED) words_sent++;
   endtask

   // Send the given header and data bytes followed by their check, low byte first.
   task automatic send_body(input logic [7:0] body[$], input logic corrupt);
      logic [15:0] chk;
      chk = (cur_mode == CHECK_SUM) ? SUM_INIT : CRC_INIT;
      foreach (body[i]) begin
         chk = check_next(cur_mode, chk, body[i]);
         send_word({OP_BYTE, body[i]});
      end
      if (corrupt) chk ^= 16'(1) << $urandom_range(15);
      send_word({OP_BYTE, chk[7:0]});
      send_word({OP_BYTE, chk[15:8]});
   endtask

   // One frame, mostly well formed; some are filtered, too long, cut short or corrupted.
   task automatic send_frame();
      logic [7:0] body[$];
      logic [7:0] func;
      logic [7:0] len;
      int         lim;
      int         pick;
      int         data_count;
      int         cut;
      lim = (int'(cur_max) > SUM_LEN_CAP) ? SUM_LEN_CAP : int'(cur_max);
      if ($urandom_range(3) == 0) send_word({OP_BYTE, 8'($urandom)});
      if (cur_mode == CHECK_SUM && $urandom_range(99) < 85) func = cur_filter;
      else func = 8'($urandom);
      pick = $urandom_range(99);
      if (cur_mode == CHECK_CRC) begin
         if (pick < 70) len = 8'($urandom_range(10));
         else if (pick < 90) len = 8'($urandom_range(DATA_CAP, SUM_LEN_CAP));
         else len = 8'($urandom);
      end else begin
         if (pick < 75) len = 8'($urandom_range(lim, 1));
         else if (pick < 85) len = 8'h00;
         else if (pick < 95) len = 8'(lim + $urandom_range(3, 1));
         else len = 8'($urandom);
      end
      data_count = (int'(len) > DATA_CAP) ? DATA_CAP : int'(len);
      body = '{cur_own, func, len};
      repeat (data_count) body.push_back(8'($urandom));
      if ($urandom_range(99) < 8) begin
         // Break the frame off with a timeout or a receive error.
         cut = $urandom_range(body.size() - 1);
         for (int i = 0; i < cut; i++) send_word({OP_BYTE, body[i]});
         send_word({$urandom_range(1) ? OP_TIMEOUT : OP_RX_ERROR, 8'($urandom)});
      end else begin
         send_body(body, $urandom_range(99) < 15);
      end
   endtask

   // Write all four registers on consecutive cycles.
   task automatic program_regs(input logic [7:0] own, input logic mode,
                               input logic [7:0] filter, input logic [5:0] max_len);
      logic [7:0] vals [4];
      vals[REG_OWN_ADDRESS] = own;
      vals[REG_CHECK_MODE] = {7'd0, mode};
      vals[REG_FUNCTION_FILTER] = filter;
      vals[REG_MAX_DATA_LENGTH] = {2'd0, max_len};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      cur_own = own;
      cur_mode = mode;
      cur_filter = filter;
      cur_max = max_len;
   endtask

   // Resynchronize the parser, then let every expected word drain out.
   task automatic drain();
      send_word({OP_RX_ERROR, 8'($urandom)});
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0] body[$];
      int         start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset register values.
      send_idle_pct = 22;
      stall_pct <= 70;
      send_word({OP_BYTE, 8'h00});
      send_word({OP_UNUSED, 8'hFF});
      body = '{cur_own, 8'hFF, 8'h00};
      send_body(body, 1'b0);
      send_word({OP_BYTE, cur_own});
      send_word({OP_BYTE, 8'h03});
      send_word({OP_TIMEOUT, 8'hFF});
      send_word({OP_BYTE, cur_own});
      send_word({OP_BYTE, 8'h10});
      send_word({OP_BYTE, 8'h01});
      send_word({OP_BYTE, 8'hAA});
      send_word({OP_RX_ERROR, 8'h55});
      body = '{cur_own, 8'h03, 8'h01, 8'h55};
      send_body(body, 1'b1);
      drain();

      // Random phases, each under its own register setting and one of three idle patterns.
      for (int p = 1; p <= PHASE_COUNT; p++) begin
         case (p)
            1: program_regs(8'h00, CHECK_CRC, 8'hFF, 6'd61);
            2: program_regs(8'hFF, CHECK_SUM, 8'h00, 6'd1);
            3: program_regs(8'($urandom), CHECK_SUM, 8'hFF, 6'd61);
            4: program_regs(8'($urandom), CHECK_SUM, 8'($urandom), 6'($urandom_range(61, 1)));
            5: program_regs(8'($urandom), CHECK_CRC, 8'($urandom), 6'($urandom_range(61, 1)));
            default: program_regs(8'($urandom), CHECK_SUM, 8'($urandom),
                                  6'($urandom_range(SUM_LEN_CAP + 1, 1)));
         endcase
         if (p <= 2) begin
            send_idle_pct = 22;
            stall_pct <= 70;
         end else if (p <= 4) begin
            send_idle_pct = 70;
            stall_pct <= 22;
         end else begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         start = words_sent;
         while (words_sent - start < WORDS_PER_PHASE) begin
            if ($urandom_range(9) == 0) send_word({2'($urandom_range(3)), 8'($urandom)});
            else send_frame();
         end
         drain();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rtu_pkg.sv
rtl/rtu_ram.sv
rtl/rtu_check_unit.sv
rtl/rtu_frame_receiver.sv
tb/sv/rtu_frame_checker.sv
tb/sv/rtu_frame_receiver_tb.sv
